// File: hw/rtl/box_subtract_defines.svh
// ----------------------------------------------------------------------------
// Box subtract assertion macros
// Shared wrappers for the concurrent assertions of the box subtract block.
// ----------------------------------------------------------------------------
`ifndef BOX_SUBTRACT_DEFINES_SVH
`define BOX_SUBTRACT_DEFINES_SVH

// Checked on every rising edge outside reset.
`define BSUB_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BSUB_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/bsub_pkg.sv
// ----------------------------------------------------------------------------
// Box subtract package
// Beat types, queue entry type and shared constants of the box subtract block.
// ----------------------------------------------------------------------------
package bsub_pkg;

	localparam int COORD_BITS      = 32;
	localparam int TAG_BITS        = 32;
	localparam int CFG_BITS        = 2;
	localparam int MAX_AXES_DEF    = 2;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int NUM_SLABS       = 4;

	localparam logic [CFG_BITS-1:0] DIMS_RESET = CFG_BITS'(2);

	localparam int SLAB_LO0 = 0;
	localparam int SLAB_HI0 = 1;
	localparam int SLAB_LO1 = 2;
	localparam int SLAB_HI1 = 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [NUM_SLABS-1:0] slab_mask_t;

	typedef enum logic [1:0] {
		KIND_DISJOINT = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_SLABS    = 2'd2
	} kind_t;

	typedef struct packed {
		coord_t a_low_axis0;
		coord_t a_high_axis0;
		coord_t a_low_axis1;
		coord_t a_high_axis1;
		coord_t b_low_axis0;
		coord_t b_high_axis0;
		coord_t b_low_axis1;
		coord_t b_high_axis1;
		tag_t   tag;
	} box_in_t;

	typedef struct packed {
		coord_t r_low_axis0;
		coord_t r_high_axis0;
		coord_t r_low_axis1;
		coord_t r_high_axis1;
		tag_t   result_tag;
		logic   is_empty;
		logic   last;
	} box_out_t;

	typedef struct packed {
		kind_t      kind;
		slab_mask_t mask;
		tag_t       tag;
		coord_t     a_lo0;
		coord_t     a_hi0;
		coord_t     a_lo1;
		coord_t     a_hi1;
		coord_t     b_lo0_m1;
		coord_t     b_hi0_p1;
		coord_t     b_lo1_m1;
		coord_t     b_hi1_p1;
		coord_t     clip_lo0;
		coord_t     clip_hi0;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// File: hw/rtl/bsub_front.sv
// ----------------------------------------------------------------------------
// Box subtract front end
// Holds the axis count register, takes command beats and classifies each pair
// of boxes into a queue entry that lists the slabs to be emitted.
// ----------------------------------------------------------------------------
module bsub_front import bsub_pkg::*; #(
	parameter int MaxAxes = MAX_AXES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  box_in_t             item,
	input  logic                cfg_we,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	input  queue_status_t       qstat,
	output logic                push,
	output job_t                job
);

	logic [CFG_BITS-1:0] dims_q;
	logic                valid_s1;
	logic                two_s1;
	box_in_t             item_s1;
	logic                accept;
	logic                two_axes;
	logic                ov0;
	logic                ov1;
	logic                overlap;
	slab_mask_t          mask;

	assign two_axes = (dims_q >= CFG_BITS'(2)) && (MaxAxes > 1);
	assign busy     = valid_s1 && qstat.full;
	assign accept   = start && !busy;
	assign push     = valid_s1 && !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q   <= DIMS_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				dims_q <= cfg_wdata;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			two_s1  <= two_axes;
		end
	end

	always_comb begin
		ov0 = (item_s1.a_low_axis0 <= item_s1.a_high_axis0)
			&& (item_s1.b_low_axis0 <= item_s1.b_high_axis0)
			&& (item_s1.a_low_axis0 <= item_s1.b_high_axis0)
			&& (item_s1.b_low_axis0 <= item_s1.a_high_axis0);
		ov1 = (item_s1.a_low_axis1 <= item_s1.a_high_axis1)
			&& (item_s1.b_low_axis1 <= item_s1.b_high_axis1)
			&& (item_s1.a_low_axis1 <= item_s1.b_high_axis1)
			&& (item_s1.b_low_axis1 <= item_s1.a_high_axis1);
		overlap = ov0 && (!two_s1 || ov1);

		mask           = '0;
		mask[SLAB_LO0] = item_s1.a_low_axis0 < item_s1.b_low_axis0;
		mask[SLAB_HI0] = item_s1.a_high_axis0 > item_s1.b_high_axis0;
		mask[SLAB_LO1] = two_s1 && (item_s1.a_low_axis1 < item_s1.b_low_axis1);
		mask[SLAB_HI1] = two_s1 && (item_s1.a_high_axis1 > item_s1.b_high_axis1);

		job = '0;
		if (!overlap) begin
			job.kind = KIND_DISJOINT;
		end else if (mask == '0) begin
			job.kind = KIND_EMPTY;
		end else begin
			job.kind = KIND_SLABS;
		end
		job.mask     = mask;
		job.tag      = item_s1.tag;
		job.a_lo0    = item_s1.a_low_axis0;
		job.a_hi0    = item_s1.a_high_axis0;
		job.a_lo1    = two_s1 ? item_s1.a_low_axis1 : '0;
		job.a_hi1    = two_s1 ? item_s1.a_high_axis1 : '0;
		job.b_lo0_m1 = item_s1.b_low_axis0 - coord_t'(1);
		job.b_hi0_p1 = item_s1.b_high_axis0 + coord_t'(1);
		job.b_lo1_m1 = item_s1.b_low_axis1 - coord_t'(1);
		job.b_hi1_p1 = item_s1.b_high_axis1 + coord_t'(1);
		job.clip_lo0 = (item_s1.a_low_axis0 > item_s1.b_low_axis0)
			? item_s1.a_low_axis0 : item_s1.b_low_axis0;
		job.clip_hi0 = (item_s1.a_high_axis0 < item_s1.b_high_axis0)
			? item_s1.a_high_axis0 : item_s1.b_high_axis0;
	end

endmodule

// File: hw/rtl/bsub_queue.sv
// ----------------------------------------------------------------------------
// Box subtract job queue
// Short first-in first-out queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module bsub_queue import bsub_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  job_t          push_job,
	input  logic          pop,
	output job_t          head,
	output queue_status_t qstat
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	job_t            entry_q [Depth];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign qstat.full  = (count_q == CW'(Depth));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: hw/rtl/bsub_back.sv
// ----------------------------------------------------------------------------
// Box subtract back end
// Walks the slab list of the job at the queue head, one result beat a cycle,
// and drives the registered result port.
// ----------------------------------------------------------------------------
module bsub_back import bsub_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  job_t          head,
	input  queue_status_t qstat,
	output logic          pop,
	output logic          result_valid,
	output box_out_t      result
);

	slab_mask_t done_q;
	slab_mask_t pending;
	slab_mask_t pick;
	logic       head_valid;
	logic       final_slab;
	logic       valid_q;
	box_out_t   result_q;
	box_out_t   res_d;

	assign head_valid = !qstat.empty;
	assign pending    = head.mask & ~done_q;
	assign pick       = pending & (~pending + slab_mask_t'(1));
	assign final_slab = (pending & ~pick) == '0;
	assign pop        = head_valid && ((head.kind != KIND_SLABS) || final_slab);

	always_comb begin
		res_d            = '0;
		res_d.result_tag = head.tag;
		res_d.last       = pop;
		unique case (head.kind)
			KIND_DISJOINT: begin
				res_d.r_low_axis0  = head.a_lo0;
				res_d.r_high_axis0 = head.a_hi0;
				res_d.r_low_axis1  = head.a_lo1;
				res_d.r_high_axis1 = head.a_hi1;
			end
			KIND_SLABS: begin
				res_d.r_low_axis0  = head.a_lo0;
				res_d.r_high_axis0 = head.a_hi0;
				res_d.r_low_axis1  = head.a_lo1;
				res_d.r_high_axis1 = head.a_hi1;
				if (pick[SLAB_LO0]) begin
					res_d.r_high_axis0 = head.b_lo0_m1;
				end else if (pick[SLAB_HI0]) begin
					res_d.r_low_axis0 = head.b_hi0_p1;
				end else begin
					res_d.r_low_axis0  = head.clip_lo0;
					res_d.r_high_axis0 = head.clip_hi0;
					if (pick[SLAB_LO1]) begin
						res_d.r_high_axis1 = head.b_lo1_m1;
					end else begin
						res_d.r_low_axis1 = head.b_hi1_p1;
					end
				end
			end
			default: begin
				res_d.is_empty = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= head_valid;
			if (head_valid) begin
				done_q <= pop ? '0 : (done_q | pick);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_valid) begin
			result_q <= res_d;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

// File: hw/rtl/box_subtract.sv
// ----------------------------------------------------------------------------
// Box subtract
// Emits box A minus box B as disjoint boxes that carry the command tag.
//
// A command beat is taken at a rising edge with start high and busy low. The
// axis count register resets to two axes and is written through cfg_we and
// cfg_wdata; the user must do so only while the block is idle (not enforced).
// Each command gives one to four result beats, one per cycle, each shown for
// exactly one cycle with result_valid high; last marks the final one. The
// first result beat of a command passes through the front register, the job
// queue and the result register before it is shown.
// A command holds the result port until its last result beat, so the
// sustained command rate is set by the back end that walks the slab list.
// Commands may follow each other on every cycle until the job queue and the
// front register are full; busy is high while they are.
// Reset empties the front register, the job queue and the result register;
// no result beat is shown during or straight after reset. The receiver takes
// every result beat as it comes.
// ----------------------------------------------------------------------------
module box_subtract import bsub_pkg::*; #(
	parameter int MaxAxes    = MAX_AXES_DEF,
	parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  box_in_t             item,
	input  logic                cfg_we,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	output logic                result_valid,
	output box_out_t            result
);

	queue_status_t qstat;
	logic          push;
	logic          pop;
	job_t          push_job;
	job_t          head;

	bsub_front #(
		.MaxAxes(MaxAxes)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.qstat    (qstat),
		.push     (push),
		.job      (push_job)
	);

	bsub_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	bsub_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

// File: hw/rtl/bsub_checker.sv
// ----------------------------------------------------------------------------
// Box subtract checker
// Port level assertions on the result beats of the box subtract block.
// ----------------------------------------------------------------------------
`include "box_subtract_defines.svh"

module bsub_checker import bsub_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     busy,
	input logic     result_valid,
	input box_out_t result
);

	`BSUB_ASSERT(a_burst_gapless, result_valid && !result.last |=> result_valid, "result burst has a gap")
	`BSUB_ASSERT(a_burst_tag, result_valid && !result.last |=> result.result_tag == $past(result.result_tag), "tag changed within a burst")
	`BSUB_ASSERT(a_empty_last, result_valid && result.is_empty |-> result.last, "empty result is not the final beat")
	`BSUB_ASSERT(a_empty_zero, result_valid && result.is_empty |-> (result.r_low_axis0 == '0) && (result.r_high_axis0 == '0) && (result.r_low_axis1 == '0) && (result.r_high_axis1 == '0), "empty result carries bounds")
	`BSUB_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !result_valid && !busy, "activity during reset")

endmodule

bind box_subtract bsub_checker u_bsub_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.busy        (busy),
	.result_valid(result_valid),
	.result      (result)
);
